// ===== sv/sccs_pkg.sv =====
// ----------------------------------------------------------------------------
// sccs_pkg: shared types and constants for the strip cluster charge sum
// Field widths, register indexes and the control word of the charge unit.
// ----------------------------------------------------------------------------
package sccs_pkg;

    // Fixed field widths of the item formats
    localparam int ADC_FIELD_W     = 12;
    localparam int NUM_BINS        = 8;
    localparam int BIN_IDX_W       = $clog2(NUM_BINS);
    localparam int THRESH_W        = 12;
    localparam int TOP_COUNT_W     = 4;
    localparam int STRIP_CHARGE_W  = 17;
    localparam int RUN_LEN_W       = 8;
    localparam int LAYER_CHARGE_W  = 19;
    localparam int LAYER_WIDTH_W   = 4;
    localparam int LAYER_CHARGE_MAX = (1 << LAYER_CHARGE_W) - 1;
    localparam int RUN_LEN_MAX     = (1 << RUN_LEN_W) - 1;

    localparam int S_TDATA_W = NUM_BINS * ADC_FIELD_W;
    localparam int M_TDATA_W = STRIP_CHARGE_W + RUN_LEN_W + LAYER_CHARGE_W + LAYER_WIDTH_W;
    localparam int M_TUSER_W = 3;

    // Parameter defaults
    localparam int TOP_MAX_DEFAULT  = 8;
    localparam int ADC_BITS_DEFAULT = 12;

    // Register reset values
    localparam logic [THRESH_W-1:0]    FIRE_THRESHOLD_RESET = '0;
    localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET      = TOP_COUNT_W'(3);

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIRE_THRESHOLD = 1'b0,
        REG_TOP_COUNT      = 1'b1
    } sccs_cfg_reg_t;

    // Control word for the shared charge unit
    typedef struct packed {
        logic clear;      // zero accumulator and fired flag
        logic add_bin;    // add one bin excess, update fired flag
        logic add_entry;  // add one kept charge
    } sccs_unit_ctl_t;

endpackage

// ===== sv/sccs_charge_unit.sv =====
// ----------------------------------------------------------------------------
// sccs_charge_unit: shared add/compare unit
// Per step either adds one bin excess (2*bin - pedestal sum) and checks it
// against the threshold, or adds one kept charge for the layer sum.
// ----------------------------------------------------------------------------
module sccs_charge_unit import sccs_pkg::*; #(
    parameter int SAMPLE_W = ADC_BITS_DEFAULT,
    parameter int CHG_W    = ADC_BITS_DEFAULT + 5,
    parameter int ACC_W    = LAYER_CHARGE_W + 1
) (
    input  logic                       aclk,
    input  sccs_unit_ctl_t             ctl,
    input  logic [SAMPLE_W-1:0]        sample,
    input  logic [SAMPLE_W:0]          ped2,
    input  logic [THRESH_W:0]          thr2,
    input  logic signed [CHG_W-1:0]    entry,
    output logic signed [ACC_W-1:0]    acc,
    output logic                       fired
);

    localparam int EX_W = SAMPLE_W + 2;

    logic signed [EX_W-1:0]  ex;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    fired_reg, fired_next;

    assign ex = $signed({1'b0, sample, 1'b0}) - $signed({1'b0, ped2});

    always_comb begin
        acc_next   = acc_reg;
        fired_next = fired_reg;
        if (ctl.clear) begin
            acc_next   = '0;
            fired_next = 1'b0;
        end else if (ctl.add_bin) begin
            acc_next   = acc_reg + ACC_W'(ex);
            fired_next = fired_reg | (int'(ex) > int'(thr2));
        end else if (ctl.add_entry) begin
            acc_next   = acc_reg + ACC_W'(entry);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        fired_reg <= fired_next;
    end

    assign acc   = acc_reg;
    assign fired = fired_reg;

endmodule

// ===== sv/sccs_top_list.sv =====
// ----------------------------------------------------------------------------
// sccs_top_list: descending list of the largest strip charges of a layer
// One write and one read address per cycle; the sequencer walks it.
// ----------------------------------------------------------------------------
module sccs_top_list import sccs_pkg::*; #(
    parameter int TOP_MAX = TOP_MAX_DEFAULT,
    parameter int CHG_W   = ADC_BITS_DEFAULT + 5,
    parameter int IDX_W   = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic signed [CHG_W-1:0] wr_data,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic signed [CHG_W-1:0] rd_data
);

    logic signed [CHG_W-1:0] entry_reg [TOP_MAX];

    always_ff @(posedge aclk) begin
        if (wr_en && (int'(wr_addr) < TOP_MAX)) begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

    // Out-of-range address only occurs on a guarded read at position zero
    assign rd_data = (int'(rd_addr) < TOP_MAX) ? entry_reg[rd_addr] : '0;

endmodule

// ===== sv/strip_cluster_charge_sum_unit.sv =====
// ----------------------------------------------------------------------------
// strip_cluster_charge_sum_unit: strip charge, run length and layer charge
// One strip per input item, one result item per strip.
// ----------------------------------------------------------------------------
// Usage: each input item is one strip with eight ADC bins; s_tlast marks the
// last strip of a layer. The pedestal is (bin0+bin1)/2, worked in half-ADC
// units. A strip fires when a bin exceeds the pedestal by more than
// fire_threshold; its charge is the sum of its eight bin excesses. Fired
// strips are counted in runs (closed by a non-fired strip or the layer end,
// saturating at 255), and the largest TOP_MAX fired charges of the layer are
// kept in a sorted list. On the last strip the result also carries the sum
// of the top_count largest charges (saturated at 2^19-1, zero if not
// positive), how many were summed and a valid mark. Timing: one item at a
// time; the insertion walk is skipped when the strip does not fire or a
// full list drops the charge, and the layer sum runs only on the last
// strip of a layer when there are charges to sum; the next item is
// accepted in the cycle after the result is loaded into the output
// register, where it is held until it is taken. The
// eight bin excesses go through one shared add/compare unit one bin per
// cycle, the insertion walks the list one entry per cycle through a single
// read port, and the layer sum reuses the same unit. s_tready is high only
// while the sequencer is idle; a finished result sits in the output register
// and the next item can be accepted before it is taken. Configuration
// writes (cfg_ready is always high) must only happen while idle.
// ----------------------------------------------------------------------------
module strip_cluster_charge_sum_unit import sccs_pkg::*; #(
    parameter int TOP_MAX  = TOP_MAX_DEFAULT,
    parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // strip input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // adc_bin0 .. adc_bin7, 12 bits each
    input  logic                   s_tlast,   // last_in_layer
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // strip_charge, run_length, layer_charge,
                                              // layer_width
    output logic [M_TUSER_W-1:0]   m_tuser,   // strip_fired, run_closed, layer_valid
    output logic                   m_tlast    // layer_done
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int SAMPLE_W  = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;
    localparam int PED_W     = SAMPLE_W + 1;
    localparam int CHG_W     = SAMPLE_W + 5;          // 8 excesses of SAMPLE_W+2 bits
    localparam int ACC_RAW_W = CHG_W + $clog2(TOP_MAX);
    localparam int ACC_W     = (ACC_RAW_W > LAYER_CHARGE_W) ? ACC_RAW_W : LAYER_CHARGE_W + 1;
    localparam int IDX_W     = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
    localparam int FILL_W    = $clog2(TOP_MAX + 1);

    localparam logic signed [ACC_W-1:0] LAYER_MAX_S = ACC_W'(LAYER_CHARGE_MAX);

    // One-hot sequencer
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EXC      = 7'b0000010,   // one bin per cycle through the charge unit
        ST_INS_CHK  = 7'b0000100,   // latch charge, pick insertion start
        ST_INS_WALK = 7'b0001000,   // shift smaller entries down one per cycle
        ST_LAYER    = 7'b0010000,   // pick the count of charges to sum
        ST_SUM      = 7'b0100000,   // add one kept charge per cycle
        ST_OUT      = 7'b1000000    // load the output register
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [THRESH_W-1:0]    fire_threshold_reg;
    logic [TOP_COUNT_W-1:0] top_count_reg;

    // Item working registers
    logic [SAMPLE_W-1:0]     bins_reg [NUM_BINS];
    logic [SAMPLE_W-1:0]     bins_next [NUM_BINS];
    logic                    last_reg, last_next;
    logic [PED_W-1:0]        ped2_reg, ped2_next;
    logic [BIN_IDX_W-1:0]    bin_idx_reg, bin_idx_next;
    logic                    fired_reg, fired_next;
    logic signed [CHG_W-1:0] charge_reg, charge_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [IDX_W-1:0]        sum_idx_reg, sum_idx_next;
    logic [TOP_COUNT_W-1:0]  n_reg, n_next;

    // Layer state
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [RUN_LEN_W-1:0]    run_count_reg, run_count_next;

    // Output register
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]    m_tuser_reg, m_tuser_next;
    logic                    m_tlast_reg, m_tlast_next;

    // Unit and list hookup
    sccs_unit_ctl_t          unit_ctl;
    logic signed [ACC_W-1:0] unit_acc;
    logic                    unit_fired;
    logic signed [CHG_W-1:0] charge_now;
    logic                    list_wr_en;
    logic [IDX_W-1:0]        list_wr_addr, list_rd_addr;
    logic signed [CHG_W-1:0] list_wr_data, list_rd_data;

    // Result fields
    logic                      run_closed;
    logic [RUN_LEN_W-1:0]      run_len;
    logic [LAYER_CHARGE_W-1:0] layer_charge;
    logic [LAYER_WIDTH_W-1:0]  layer_width;
    logic                      layer_valid;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == ST_IDLE);
    assign charge_now = CHG_W'(unit_acc);

    // ------------------------------------------------------------------
    // Shared charge unit and kept-charge list
    // ------------------------------------------------------------------
    sccs_charge_unit #(
        .SAMPLE_W (SAMPLE_W),
        .CHG_W    (CHG_W),
        .ACC_W    (ACC_W)
    ) u_unit (
        .aclk   (aclk),
        .ctl    (unit_ctl),
        .sample (bins_reg[bin_idx_reg]),
        .ped2   (ped2_reg),
        .thr2   ({fire_threshold_reg, 1'b0}),
        .entry  (list_rd_data),
        .acc    (unit_acc),
        .fired  (unit_fired)
    );

    sccs_top_list #(
        .TOP_MAX (TOP_MAX),
        .CHG_W   (CHG_W),
        .IDX_W   (IDX_W)
    ) u_list (
        .aclk    (aclk),
        .wr_en   (list_wr_en),
        .wr_addr (list_wr_addr),
        .wr_data (list_wr_data),
        .rd_addr (list_rd_addr),
        .rd_data (list_rd_data)
    );

    // ------------------------------------------------------------------
    // Result fields, valid in ST_OUT
    // ------------------------------------------------------------------
    always_comb begin
        run_closed   = !fired_reg || last_reg;
        run_len      = '0;
        layer_charge = '0;
        layer_width  = '0;
        layer_valid  = 1'b0;
        if (run_closed) begin
            if (fired_reg && (run_count_reg != RUN_LEN_W'(RUN_LEN_MAX))) begin
                run_len = run_count_reg + 1'b1;
            end else begin
                run_len = fired_reg ? RUN_LEN_W'(RUN_LEN_MAX) : run_count_reg;
            end
        end
        if (last_reg) begin
            layer_width = LAYER_WIDTH_W'(n_reg);
            if (unit_acc > 0) begin
                layer_valid  = 1'b1;
                layer_charge = (unit_acc > LAYER_MAX_S) ? LAYER_CHARGE_W'(LAYER_CHARGE_MAX)
                                                        : unit_acc[LAYER_CHARGE_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        bins_next      = bins_reg;
        last_next      = last_reg;
        ped2_next      = ped2_reg;
        bin_idx_next   = bin_idx_reg;
        fired_next     = fired_reg;
        charge_next    = charge_reg;
        pos_next       = pos_reg;
        sum_idx_next   = sum_idx_reg;
        n_next         = n_reg;
        fill_next      = fill_reg;
        run_count_next = run_count_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        unit_ctl       = '0;
        list_wr_en     = 1'b0;
        list_wr_addr   = pos_reg;
        list_wr_data   = charge_reg;
        list_rd_addr   = pos_reg - 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < NUM_BINS; i++) begin
                        bins_next[i] = s_tdata[i*ADC_FIELD_W +: SAMPLE_W];
                    end
                    last_next    = s_tlast;
                    ped2_next    = PED_W'(s_tdata[0 +: SAMPLE_W])
                                 + PED_W'(s_tdata[ADC_FIELD_W +: SAMPLE_W]);
                    bin_idx_next = '0;
                    unit_ctl.clear = 1'b1;
                    state_next   = ST_EXC;
                end
            end
            ST_EXC: begin
                unit_ctl.add_bin = 1'b1;
                bin_idx_next     = bin_idx_reg + 1'b1;
                if (bin_idx_reg == BIN_IDX_W'(NUM_BINS - 1)) begin
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                list_rd_addr = IDX_W'(TOP_MAX - 1);
                fired_next   = unit_fired;
                charge_next  = unit_fired ? charge_now : '0;
                if (!unit_fired) begin
                    state_next = ST_LAYER;
                end else if (int'(fill_reg) < TOP_MAX) begin
                    pos_next   = IDX_W'(fill_reg);
                    fill_next  = fill_reg + 1'b1;
                    state_next = ST_INS_WALK;
                end else if (charge_now <= list_rd_data) begin
                    // full list, new charge no larger than the smallest kept
                    state_next = ST_LAYER;
                end else begin
                    pos_next   = IDX_W'(TOP_MAX - 1);
                    state_next = ST_INS_WALK;
                end
            end
            ST_INS_WALK: begin
                list_wr_en = 1'b1;
                if ((pos_reg != '0) && (list_rd_data < charge_reg)) begin
                    list_wr_data = list_rd_data;
                    pos_next     = pos_reg - 1'b1;
                end else begin
                    list_wr_data = charge_reg;
                    state_next   = ST_LAYER;
                end
            end
            ST_LAYER: begin
                unit_ctl.clear = 1'b1;
                sum_idx_next   = '0;
                // fill never exceeds TOP_MAX, so this also clamps to TOP_MAX
                n_next = (int'(top_count_reg) < int'(fill_reg)) ? top_count_reg
                                                               : TOP_COUNT_W'(fill_reg);
                if (last_reg && (n_next != '0)) begin
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SUM: begin
                list_rd_addr       = sum_idx_reg;
                unit_ctl.add_entry = 1'b1;
                sum_idx_next       = sum_idx_reg + 1'b1;
                if (int'(sum_idx_reg) + 1 == int'(n_reg)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {layer_width, layer_charge, run_len,
                                     STRIP_CHARGE_W'(charge_reg)};
                    m_tuser_next  = {layer_valid, run_closed, fired_reg};
                    m_tlast_next  = last_reg;
                    if (run_closed) begin
                        run_count_next = '0;
                    end else if (run_count_reg != RUN_LEN_W'(RUN_LEN_MAX)) begin
                        run_count_next = run_count_reg + 1'b1;
                    end
                    if (last_reg) begin
                        fill_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            run_count_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            run_count_reg <= run_count_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bins_reg    <= bins_next;
        last_reg    <= last_next;
        ped2_reg    <= ped2_next;
        bin_idx_reg <= bin_idx_next;
        fired_reg   <= fired_next;
        charge_reg  <= charge_next;
        pos_reg     <= pos_next;
        sum_idx_reg <= sum_idx_next;
        n_reg       <= n_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_threshold_reg <= FIRE_THRESHOLD_RESET;
            top_count_reg      <= TOP_COUNT_RESET;
        end else if (cfg_valid) begin
            case (sccs_cfg_reg_t'(cfg_index))
                REG_FIRE_THRESHOLD: fire_threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_TOP_COUNT:      top_count_reg      <= cfg_data[TOP_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // one item at a time: no accept in the cycle after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous item still in work");

    // kept-charge count never exceeds the list depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= TOP_MAX)
        else $error("top list fill count overflow");

    // layer fields are zero unless the item ends the layer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[M_TDATA_W-1:STRIP_CHARGE_W+RUN_LEN_W] == '0
                                    && !m_tuser[2]))
        else $error("layer result on a strip that does not end the layer");

    // run length only reported on a closed run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |->
            (m_tdata[STRIP_CHARGE_W +: RUN_LEN_W] == '0))
        else $error("run length reported on an open run");

endmodule
